### hw/rtl/bole_pkg.sv
// Shared constants, status and command codes, and the result record of the list engine.
package bole_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int CMD_W    = 3;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 6;
  localparam int STAT_W   = 3;
  // common width for comparing the position field against the count
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [CMD_W-1:0] CMD_CREATE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd4;
  localparam logic [CMD_W-1:0] CMD_MIDDLE = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] found_value;
    logic [POS_W-1:0]        found_position;
  } res_t;

endpackage

### hw/rtl/bounded_ordered_list_engine_top.sv
// Top level of the ordered list engine: sequencer plus result output register.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   in_cmd, in_item_value, in_slot_position
//   out_     output     out_valid/out_stall out_status, out_found_value,
//                                           out_found_position
//
// One item at a time: no new command is taken until the last result has passed to the
// output register. Insert and delete away from the tail shift the list, and search scans
// it, with one RAM access per cycle; middle reads a single entry.
// Reset clears the element count; the list RAM is not cleared.
// A result waits in the output register under out_stall; the sequencer holds
// its next result until that register frees.
module bounded_ordered_list_engine_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bole_pkg::CMD_W-1:0]        in_cmd,
  input  logic signed [bole_pkg::VAL_W-1:0] in_item_value,
  input  logic [bole_pkg::POS_W-1:0]        in_slot_position,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bole_pkg::STAT_W-1:0]       out_status,
  output logic signed [bole_pkg::VAL_W-1:0] out_found_value,
  output logic [bole_pkg::POS_W-1:0]        out_found_position
);
  import bole_pkg::*;

  logic res_valid, res_ready;
  res_t res;
  logic out_valid_r, out_valid_nxt;
  res_t out_r;

  bole_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_item_value    (in_item_value),
    .in_slot_position (in_slot_position),
    .res_valid        (res_valid),
    .res              (res),
    .res_ready        (res_ready)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_found_value    = out_r.found_value;
  assign out_found_position = out_r.found_position;

endmodule

### hw/rtl/bole_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
module bole_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/bole_ctrl.sv
// Command sequencer: decodes an item, walks or shifts the list RAM, forms the result.
module bole_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bole_pkg::CMD_W-1:0]  in_cmd,
  input  logic signed [bole_pkg::VAL_W-1:0] in_item_value,
  input  logic [bole_pkg::POS_W-1:0]  in_slot_position,
  output logic                        res_valid,
  output bole_pkg::res_t              res,
  input  logic                        res_ready
);
  import bole_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SHIFT = 6'b000010,
    S_FILL  = 6'b000100,
    S_SCAN  = 6'b001000,
    S_MID   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] pos0_r, pos0_nxt;
  logic             ins_r, ins_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  res_t             res_r, res_nxt;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  logic [VAL_W-1:0] wdata, rdata;

  logic [CMP_W-1:0] pos_w, cnt_w;
  logic             full, empty;

  bole_ram #(.DEPTH(CAPACITY), .WIDTH(VAL_W)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign pos_w = CMP_W'(in_slot_position);
  assign cnt_w = CMP_W'(count_r);
  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  assign in_stall  = (state_r != S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    pos0_nxt  = pos0_r;
    ins_nxt   = ins_r;
    count_nxt = count_r;
    val_nxt   = val_r;
    res_nxt   = res_r;
    we        = 1'b0;
    waddr     = idx_r;
    wdata     = rdata;
    raddr     = idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt   = in_item_value;
          res_nxt   = '{status: ST_OK, found_value: '0, found_position: '0};
          state_nxt = S_DONE;
          case (in_cmd)
            CMD_CREATE: begin
              we        = 1'b1;
              waddr     = '0;
              wdata     = in_item_value;
              count_nxt = CNT_W'(1);
            end
            CMD_APPEND: begin
              if (full) begin
                res_nxt.status = ST_FULL;
              end else begin
                we        = 1'b1;
                waddr     = IDX_W'(count_r);
                wdata     = in_item_value;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_INSERT: begin
              if (full) begin
                res_nxt.status = ST_FULL;
              end else if (pos_w == '0 || pos_w > cnt_w + CMP_W'(1)) begin
                res_nxt.status = ST_BADPOS;
              end else if (pos_w == cnt_w + CMP_W'(1)) begin
                // insert just past the tail: nothing to move
                we        = 1'b1;
                waddr     = IDX_W'(pos_w - CMP_W'(1));
                wdata     = in_item_value;
                count_nxt = count_r + CNT_W'(1);
              end else begin
                raddr     = IDX_W'(count_r - CNT_W'(1));
                idx_nxt   = IDX_W'(count_r);
                pos0_nxt  = IDX_W'(pos_w - CMP_W'(1));
                ins_nxt   = 1'b1;
                state_nxt = S_SHIFT;
              end
            end
            CMD_DELETE: begin
              if (empty) begin
                res_nxt.status = ST_EMPTY;
              end else if (pos_w == '0 || pos_w > cnt_w) begin
                res_nxt.status = ST_BADPOS;
              end else if (pos_w == cnt_w) begin
                count_nxt = count_r - CNT_W'(1);
              end else begin
                raddr     = IDX_W'(pos_w);
                idx_nxt   = IDX_W'(pos_w - CMP_W'(1));
                ins_nxt   = 1'b0;
                state_nxt = S_SHIFT;
              end
            end
            CMD_SEARCH: begin
              if (empty) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                raddr     = '0;
                idx_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            CMD_MIDDLE: begin
              if (empty) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                raddr     = IDX_W'(count_r >> 1);
                state_nxt = S_MID;
              end
            end
            default: ;
          endcase
        end
      end
      S_SHIFT: begin
        // read data is the neighbour fetched last cycle; store it one place over
        we    = 1'b1;
        waddr = idx_r;
        wdata = rdata;
        if (ins_r) begin
          if (CNT_W'(idx_r) == CNT_W'(pos0_r) + CNT_W'(1)) begin
            state_nxt = S_FILL;
          end else begin
            idx_nxt = idx_r - IDX_W'(1);
            raddr   = IDX_W'(CNT_W'(idx_r) - CNT_W'(2));
          end
        end else begin
          if (CNT_W'(idx_r) + CNT_W'(2) == count_r) begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_DONE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
            raddr   = IDX_W'(CNT_W'(idx_r) + CNT_W'(2));
          end
        end
      end
      S_FILL: begin
        we        = 1'b1;
        waddr     = pos0_r;
        wdata     = val_r;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        if (rdata == val_r) begin
          res_nxt.found_position = POS_W'({1'b0, idx_r} + (IDX_W+1)'(1));
          state_nxt              = S_DONE;
        end else if (CNT_W'(idx_r) + CNT_W'(1) == count_r) begin
          res_nxt.status = ST_NOTFOUND;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
          raddr   = idx_r + IDX_W'(1);
        end
      end
      S_MID: begin
        res_nxt.found_value = rdata;
        state_nxt           = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    pos0_r <= pos0_nxt;
    ins_r  <= ins_nxt;
    val_r  <= val_nxt;
    res_r  <= res_nxt;
  end

endmodule

### hw/rtl/bole_checker.sv
// Port-level checks on the list engine, bound to its top level.
module bole_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [bole_pkg::STAT_W-1:0]       out_status,
  input logic signed [bole_pkg::VAL_W-1:0] out_found_value,
  input logic [bole_pkg::POS_W-1:0]        out_found_position
);
  import bole_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item taken while previous item still in work");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_found_value == '0 && out_found_position == '0))
    else $error("failed command carries a value or position");

  a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found_value != '0) |-> (out_found_position == '0))
    else $error("value and position both set");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_status) && $stable(out_found_value)
       && $stable(out_found_position)))
    else $error("stalled result changed");

endmodule

bind bounded_ordered_list_engine_top bole_checker u_bole_checker (.*);

### test/bounded_ordered_list_engine_top_tb.sv
// Self-checking testbench for the ordered list engine: a directed table, then random commands.
module bounded_ordered_list_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bole_pkg::*;

  localparam int N_RANDOM    = 2000;
  localparam int QUIET_TAIL  = 250;
  localparam int DRAIN_WAIT  = 2 * (CAPACITY + 4);
  localparam int STUCK_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 300;

  // spare command codes, ignored by the block
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        pos;
    int                      reps;
    bit                      typed;
    res_t                    want;
  } dir_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [CMD_W-1:0]        in_cmd = '0;
  logic signed [VAL_W-1:0] in_item_value = '0;
  logic [POS_W-1:0]        in_slot_position = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [STAT_W-1:0]       out_status;
  logic signed [VAL_W-1:0] out_found_value;
  logic [POS_W-1:0]        out_found_position;

  // shadow copy of the list contents
  logic signed [VAL_W-1:0] shadow_list [CAPACITY];
  int                      shadow_count = 0;

  res_t     pending_results[$];
  dir_row_t dir_tab[$];
  int       err_count    = 0;
  int       stuck_cycles = 0;
  bit       stim_done    = 1'b0;
  bit       quiet        = 1'b0;

  bounded_ordered_list_engine_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_item_value      (in_item_value),
    .in_slot_position   (in_slot_position),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_found_value    (out_found_value),
    .out_found_position (out_found_position)
  );

  always #5 clk = ~clk;

  // Applies one command to the shadow list and returns the result it gives.
  function automatic res_t apply_list_cmd(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] v,
                                          logic [POS_W-1:0] p);
    res_t r;
    int   k;
    int   pi;
    r = '0;
    r.status = ST_OK;
    pi = int'(p);
    case (cmd)
      CMD_CREATE: begin
        shadow_list[0] = v;
        shadow_count = 1;
      end
      CMD_APPEND: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_list[shadow_count] = v;
          shadow_count++;
        end
      end
      CMD_INSERT: begin
        // fullness wins over a bad position
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (pi < 1 || pi > shadow_count + 1) begin
          r.status = ST_BADPOS;
        end else begin
          for (k = shadow_count; k > pi - 1; k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[pi-1] = v;
          shadow_count++;
        end
      end
      CMD_DELETE: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else if (pi < 1 || pi > shadow_count) begin
          r.status = ST_BADPOS;
        end else begin
          for (k = pi - 1; k + 1 < shadow_count; k++) shadow_list[k] = shadow_list[k+1];
          shadow_count--;
        end
      end
      CMD_SEARCH: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_NOTFOUND;
          for (k = 0; k < shadow_count; k++) begin
            if (shadow_list[k] == v) begin
              r.status = ST_OK;
              r.found_position = POS_W'(k + 1);
              break;
            end
          end
        end
      end
      CMD_MIDDLE: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else r.found_value = shadow_list[shadow_count / 2];
      end
      default: ;
    endcase
    return r;
  endfunction

  // Mostly values already held or a small pool, so that searches hit.
  function automatic logic signed [VAL_W-1:0] draw_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4 && shadow_count > 0) return shadow_list[$urandom_range(0, shadow_count - 1)];
    if (sel < 7) return int'($urandom_range(0, 6)) - 3;
    if (sel == 7) return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
    return $urandom;
  endfunction

  function automatic dir_row_t tab_row(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] v,
                                       logic [POS_W-1:0] p, int reps, bit typed,
                                       logic [STAT_W-1:0] st, logic signed [VAL_W-1:0] fv,
                                       logic [POS_W-1:0] fp);
    dir_row_t d;
    d.cmd = cmd;
    d.value = v;
    d.pos = p;
    d.reps = reps;
    d.typed = typed;
    d.want.status = st;
    d.want.found_value = fv;
    d.want.found_position = fp;
    return d;
  endfunction

  initial begin
    // empty list cases
    dir_tab.push_back(tab_row(CMD_SEARCH, 7, 0, 1, 1, ST_EMPTY, 0, 0));
    dir_tab.push_back(tab_row(CMD_MIDDLE, 0, 0, 1, 1, ST_EMPTY, 0, 0));
    dir_tab.push_back(tab_row(CMD_DELETE, 0, 1, 1, 1, ST_EMPTY, 0, 0));
    dir_tab.push_back(tab_row(CMD_INSERT, 1, 0, 1, 1, ST_BADPOS, 0, 0));
    dir_tab.push_back(tab_row(CMD_INSERT, 1, 2, 1, 1, ST_BADPOS, 0, 0));
    dir_tab.push_back(tab_row(CMD_INSERT, VAL_MAX, 1, 1, 1, ST_OK, 0, 0));
    // create drops the previous contents
    dir_tab.push_back(tab_row(CMD_CREATE, VAL_MIN, 0, 1, 1, ST_OK, 0, 0));
    dir_tab.push_back(tab_row(CMD_MIDDLE, 0, 0, 1, 1, ST_OK, VAL_MIN, 0));
    dir_tab.push_back(tab_row(CMD_APPEND, -1, 0, 1, 0, ST_OK, 0, 0));
    dir_tab.push_back(tab_row(CMD_INSERT, 0, 1, 1, 0, ST_OK, 0, 0));
    dir_tab.push_back(tab_row(CMD_SEARCH, -1, 0, 1, 1, ST_OK, 0, 3));
    dir_tab.push_back(tab_row(CMD_SEARCH, 5, 0, 1, 1, ST_NOTFOUND, 0, 0));
    dir_tab.push_back(tab_row(CMD_MIDDLE, 0, 0, 1, 1, ST_OK, VAL_MIN, 0));
    dir_tab.push_back(tab_row(CMD_DELETE, 0, 1, 1, 0, ST_OK, 0, 0));
    dir_tab.push_back(tab_row(CMD_DELETE, 0, 3, 1, 1, ST_BADPOS, 0, 0));
    dir_tab.push_back(tab_row(CMD_DELETE, 0, 0, 1, 1, ST_BADPOS, 0, 0));
    dir_tab.push_back(tab_row(CMD_INSERT, VAL_MAX, 3, 1, 0, ST_OK, 0, 0));
    dir_tab.push_back(tab_row(CMD_SPARE_LO, 5, 5, 1, 1, ST_OK, 0, 0));
    dir_tab.push_back(tab_row(CMD_SPARE_HI, -1, 63, 1, 1, ST_OK, 0, 0));
    dir_tab.push_back(tab_row(CMD_INSERT, 4, 63, 1, 1, ST_BADPOS, 0, 0));
    dir_tab.push_back(tab_row(CMD_DELETE, 0, 63, 1, 1, ST_BADPOS, 0, 0));
    dir_tab.push_back(tab_row(CMD_SEARCH, VAL_MAX, 0, 1, 1, ST_OK, 0, 3));
    // fill up, then the full cases
    dir_tab.push_back(tab_row(CMD_APPEND, 12345, 0, CAPACITY - 3, 0, ST_OK, 0, 0));
    dir_tab.push_back(tab_row(CMD_APPEND, 1, 0, 1, 1, ST_FULL, 0, 0));
    dir_tab.push_back(tab_row(CMD_INSERT, 1, 0, 1, 1, ST_FULL, 0, 0));
    dir_tab.push_back(tab_row(CMD_MIDDLE, 0, 0, 1, 1, ST_OK, 12345, 0));
    dir_tab.push_back(tab_row(CMD_DELETE, 0, POS_W'(CAPACITY), 1, 0, ST_OK, 0, 0));
    dir_tab.push_back(tab_row(CMD_INSERT, 9, POS_W'(CAPACITY + 1), 1, 1, ST_BADPOS, 0, 0));
    dir_tab.push_back(tab_row(CMD_INSERT, 9, POS_W'(CAPACITY), 1, 0, ST_OK, 0, 0));
    dir_tab.push_back(tab_row(CMD_DELETE, 0, 1, 1, 0, ST_OK, 0, 0));
  end

  // sender: directed table first, then random commands
  int       dir_idx    = 0;
  int       rep_done   = 0;
  int       rnd_sent   = 0;
  int       gap_left   = 0;
  int       mix_mode   = 2;
  bit       tx_idle_on = 1'b1;
  bit       cur_typed  = 1'b0;
  res_t     cur_want;
  int       mode_cuts [3][6] = '{'{35, 70, 75, 87, 96, 97},
                                 '{10, 20, 70, 85, 97, 98},
                                 '{20, 40, 65, 83, 95, 97}};

  always @(posedge clk) begin
    bit                      take;
    bit                      nv;
    res_t                    pred;
    dir_row_t                d;
    int                      roll;
    logic [CMD_W-1:0]        nc;
    logic signed [VAL_W-1:0] nval;
    logic [POS_W-1:0]        npos;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      take = in_valid && !in_stall;
      if (take) begin
        pred = apply_list_cmd(in_cmd, in_item_value, in_slot_position);
        pending_results.push_back(cur_typed ? cur_want : pred);
        if (!quiet && tx_idle_on && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 9);
      end
      nv = in_valid && !take;
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (dir_idx < dir_tab.size()) begin
          d = dir_tab[dir_idx];
          rep_done++;
          if (rep_done >= d.reps) begin
            dir_idx++;
            rep_done = 0;
          end
          in_cmd <= d.cmd;
          in_item_value <= d.value;
          in_slot_position <= d.pos;
          cur_typed = d.typed;
          cur_want = d.want;
          nv = 1'b1;
        end else if (rnd_sent < N_RANDOM) begin
          if (rnd_sent % 64 == 0) begin
            mix_mode = $urandom_range(0, 2);
            tx_idle_on = ($urandom_range(0, 3) != 0);
          end
          roll = $urandom_range(0, 99);
          if (roll < mode_cuts[mix_mode][0]) nc = CMD_APPEND;
          else if (roll < mode_cuts[mix_mode][1]) nc = CMD_INSERT;
          else if (roll < mode_cuts[mix_mode][2]) nc = CMD_DELETE;
          else if (roll < mode_cuts[mix_mode][3]) nc = CMD_SEARCH;
          else if (roll < mode_cuts[mix_mode][4]) nc = CMD_MIDDLE;
          else if (roll < mode_cuts[mix_mode][5]) nc = CMD_CREATE;
          else nc = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
          nval = draw_value();
          // mostly legal positions, some anywhere in the field
          if ($urandom_range(0, 4) == 0) npos = POS_W'($urandom_range(0, 63));
          else if (nc == CMD_INSERT) npos = POS_W'($urandom_range(1, shadow_count + 1));
          else if (nc == CMD_DELETE)
            npos = (shadow_count == 0) ? POS_W'(1) : POS_W'($urandom_range(1, shadow_count));
          else npos = POS_W'($urandom_range(0, 63));
          in_cmd <= nc;
          in_item_value <= nval;
          in_slot_position <= npos;
          cur_typed = 1'b0;
          rnd_sent++;
          quiet <= (rnd_sent >= N_RANDOM - QUIET_TAIL);
          nv = 1'b1;
        end else begin
          stim_done = 1'b1;
        end
      end
      in_valid <= nv;
    end
  end

  // receiver: random stall bursts, one long hold-off, and the result check
  int   results_seen  = 0;
  int   stall_left    = 0;
  int   hold_left     = 0;
  bit   pressure_done = 1'b0;
  bit   rx_idle_on    = 1'b1;

  always @(posedge clk) begin
    res_t want;
    bit   st;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if ($urandom_range(0, 99) == 0) rx_idle_on = !rx_idle_on;
        if (pending_results.size() == 0) begin
          $error("result with no item pending: status %0d", out_status);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            err_count++;
          end
          if (out_found_value !== want.found_value) begin
            $error("found_value: expected %0d, got %0d", want.found_value, out_found_value);
            err_count++;
          end
          if (out_found_position !== want.found_position) begin
            $error("found_position: expected %0d, got %0d", want.found_position,
                   out_found_position);
            err_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        st = 1'b1;
      end else if (!pressure_done && results_seen >= HOLD_AFTER) begin
        // long hold-off so the input side backs up
        pressure_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        st = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        st = 1'b1;
      end else if (!quiet && rx_idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 8);
        st = 1'b1;
      end else begin
        st = 1'b0;
      end
      out_stall <= st;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  initial begin : watchdog
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
